FILE: hdl/mtws_pkg.sv
package mtws_pkg;

    localparam int MAX_DIM    = 8;
    localparam int DATA_WIDTH = 32;

    localparam int ELEM_W  = 32;
    localparam int POS_W   = 3;
    localparam int CNT_W   = 4;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = 2 * DIM_W;

    localparam logic [CNT_W-1:0] COUNT_RESET = 4'd8;

    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    function automatic logic [CNT_W-1:0] eff_dim(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            r = CNT_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: hdl/mtws_ram.sv
module mtws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

FILE: hdl/matrix_transpose_with_stats.sv
// channel  | valid    | stall    | payload
// input    | i_valid  | o_stall  | i_element
// output   | o_valid  | i_stall  | o_out_element, o_is_last, stats and flags
// config   | psel/penable/pwrite, pready tied high | paddr, pwdata, prdata
//
// loading writes each accepted element straight into the store ram
// after the last element: the S_PRIME state waits for the registered ram read, then
// one result per cycle while i_stall is low from the ram read ports, rows*cols results;
// input is stalled meanwhile
// reset: counts go to 8, load restarts at element 0,0; the store is not cleared
// output stall holds the read address, so the result stays on the ports
module matrix_transpose_with_stats (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [mtws_pkg::ELEM_W-1:0]   i_element,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [mtws_pkg::ELEM_W-1:0]   o_out_element,
    output logic                                 o_is_last,
    output logic [mtws_pkg::POS_W-1:0]           o_min_row,
    output logic [mtws_pkg::POS_W-1:0]           o_min_col,
    output logic [mtws_pkg::POS_W-1:0]           o_max_row,
    output logic [mtws_pkg::POS_W-1:0]           o_max_col,
    output logic                                 o_square_flag,
    output logic                                 o_identity_flag,
    output logic                                 o_symmetric_flag,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mtws_pkg::PADDR_W-1:0]         paddr,
    input  logic [mtws_pkg::PDATA_W-1:0]         pwdata,
    output logic [mtws_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);
    import mtws_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD  = 3'b001,
        S_PRIME = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]      r_row_count, r_col_count;
    logic [CNT_W-1:0]      rows_eff, cols_eff;
    logic [DIM_W-1:0]      rows_last, cols_last;

    logic [DIM_W-1:0]      r_ld_row, n_ld_row, r_ld_col, n_ld_col;
    logic [ADDR_W-1:0]     r_ld_addr, n_ld_addr;
    logic                  r_ident, n_ident;
    logic [DIM_W-1:0]      r_ei, n_ei, r_ej, n_ej;
    logic                  r_sym, n_sym;

    logic signed [DATA_WIDTH-1:0] r_min, n_min, r_max, n_max;
    logic [DIM_W-1:0]      r_min_row, n_min_row, r_min_col, n_min_col;
    logic [DIM_W-1:0]      r_max_row, n_max_row, r_max_col, n_max_col;

    logic                  in_take, cfg_wr, last, square, pair_eq;
    logic signed [DATA_WIDTH-1:0] v;
    logic [ADDR_W-1:0]     raddr_a, raddr_b;
    logic [DATA_WIDTH-1:0] rd_a, rd_b;

    assign rows_eff  = eff_dim(r_row_count);
    assign cols_eff  = eff_dim(r_col_count);
    assign rows_last = DIM_W'(rows_eff - CNT_W'(1));
    assign cols_last = DIM_W'(cols_eff - CNT_W'(1));
    assign square    = (rows_eff == cols_eff);

    assign o_stall = (r_state != S_LOAD);
    assign in_take = i_valid && (r_state == S_LOAD);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign v       = i_element[DATA_WIDTH-1:0];

    always_comb begin
        case (paddr[2])
            REG_ROW_COUNT: prdata = PDATA_W'(r_row_count);
            REG_COL_COUNT: prdata = PDATA_W'(r_col_count);
            default:       prdata = '0;
        endcase
    end

    assign last    = (r_state == S_EMIT) && (r_ei == cols_last) && (r_ej == rows_last);
    assign pair_eq = (rd_a == rd_b);

    always_comb begin
        n_state   = r_state;
        n_ld_row  = r_ld_row;
        n_ld_col  = r_ld_col;
        n_ld_addr = r_ld_addr;
        n_ident   = r_ident;
        n_ei      = r_ei;
        n_ej      = r_ej;
        n_sym     = r_sym;
        n_min     = r_min;
        n_max     = r_max;
        n_min_row = r_min_row;
        n_min_col = r_min_col;
        n_max_row = r_max_row;
        n_max_col = r_max_col;
        case (r_state)
            S_LOAD: begin
                if (in_take) begin
                    n_ld_addr = r_ld_addr + ADDR_W'(1);
                    if ((r_ld_row == '0) && (r_ld_col == '0)) begin
                        n_min     = v;
                        n_max     = v;
                        n_min_row = '0;
                        n_min_col = '0;
                        n_max_row = '0;
                        n_max_col = '0;
                    end else begin
                        if (v < r_min) begin
                            n_min     = v;
                            n_min_row = r_ld_row;
                            n_min_col = r_ld_col;
                        end
                        if (r_max < v) begin
                            n_max     = v;
                            n_max_row = r_ld_row;
                            n_max_col = r_ld_col;
                        end
                    end
                    if (r_ld_row == r_ld_col) begin
                        if (v != DATA_WIDTH'(1)) begin
                            n_ident = 1'b0;
                        end
                    end else if (v != '0) begin
                        n_ident = 1'b0;
                    end
                    if (r_ld_col == cols_last) begin
                        n_ld_col = '0;
                        if (r_ld_row == rows_last) begin
                            n_state   = S_PRIME;
                            n_ld_row  = '0;
                            n_ld_addr = '0;
                            n_ei      = '0;
                            n_ej      = '0;
                            n_sym     = 1'b1;
                        end else begin
                            n_ld_row = r_ld_row + DIM_W'(1);
                        end
                    end else begin
                        n_ld_col = r_ld_col + DIM_W'(1);
                    end
                end
                if (cfg_wr) begin
                    n_ld_row  = '0;
                    n_ld_col  = '0;
                    n_ld_addr = '0;
                    n_ident   = 1'b1;
                    n_state   = S_LOAD;
                end
            end
            S_PRIME: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_stall) begin
                    if (last) begin
                        n_state = S_LOAD;
                        n_ident = 1'b1;
                    end else begin
                        n_sym = r_sym && pair_eq;
                        if (r_ej == rows_last) begin
                            n_ej = '0;
                            n_ei = r_ei + DIM_W'(1);
                        end else begin
                            n_ej = r_ej + DIM_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // read addresses follow the next indices so ram data lines up with r_ei/r_ej
    assign raddr_a = ADDR_W'(ADDR_W'(n_ej) * ADDR_W'(cols_eff) + ADDR_W'(n_ei));
    assign raddr_b = ADDR_W'(ADDR_W'(n_ei) * ADDR_W'(cols_eff) + ADDR_W'(n_ej));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_row_count <= COUNT_RESET;
            r_col_count <= COUNT_RESET;
            r_ld_row    <= '0;
            r_ld_col    <= '0;
            r_ld_addr   <= '0;
            r_ident     <= 1'b1;
            r_ei        <= '0;
            r_ej        <= '0;
            r_sym       <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_ld_row  <= n_ld_row;
            r_ld_col  <= n_ld_col;
            r_ld_addr <= n_ld_addr;
            r_ident   <= n_ident;
            r_ei      <= n_ei;
            r_ej      <= n_ej;
            r_sym     <= n_sym;
            if (cfg_wr) begin
                case (paddr[2])
                    REG_ROW_COUNT: r_row_count <= pwdata[CNT_W-1:0];
                    REG_COL_COUNT: r_col_count <= pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_min     <= n_min;
        r_max     <= n_max;
        r_min_row <= n_min_row;
        r_min_col <= n_min_col;
        r_max_row <= n_max_row;
        r_max_col <= n_max_col;
    end

    mtws_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (in_take),
        .i_waddr   (r_ld_addr),
        .i_wdata   (v),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign o_valid          = (r_state == S_EMIT);
    assign o_out_element    = ELEM_W'(signed'(rd_a));
    assign o_is_last        = last;
    assign o_min_row        = last ? POS_W'(r_min_row) : '0;
    assign o_min_col        = last ? POS_W'(r_min_col) : '0;
    assign o_max_row        = last ? POS_W'(r_max_row) : '0;
    assign o_max_col        = last ? POS_W'(r_max_col) : '0;
    assign o_square_flag    = last && square;
    assign o_identity_flag  = last && square && r_ident;
    assign o_symmetric_flag = last && square && r_sym && pair_eq;

endmodule

FILE: hdl/mtws_checker.sv
module mtws_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_stall,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic signed [mtws_pkg::ELEM_W-1:0] o_out_element,
    input logic                               o_is_last,
    input logic [mtws_pkg::POS_W-1:0]         o_min_row,
    input logic [mtws_pkg::POS_W-1:0]         o_min_col,
    input logic [mtws_pkg::POS_W-1:0]         o_max_row,
    input logic [mtws_pkg::POS_W-1:0]         o_max_col,
    input logic                               o_square_flag,
    input logic                               o_identity_flag,
    input logic                               o_symmetric_flag
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_element) && $stable(o_is_last))
        else $error("stalled output item changed");

    a_no_load_during_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input accepted while results pending");

    a_stats_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_last |-> (o_min_row == '0) && (o_min_col == '0)
            && (o_max_row == '0) && (o_max_col == '0) && !o_square_flag
            && !o_identity_flag && !o_symmetric_flag)
        else $error("stats on a non-final item");

    a_flags_need_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_identity_flag || o_symmetric_flag) |-> o_square_flag)
        else $error("identity or symmetric flag without square");

    a_last_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_last && !i_stall |=> !o_valid && !o_stall)
        else $error("block not back to loading after final item");

endmodule

bind matrix_transpose_with_stats mtws_checker u_mtws_checker (.*);

FILE: test/tb_matrix_transpose_with_stats.sv
`timescale 1ns / 100ps

module tb_matrix_transpose_with_stats;
    import mtws_pkg::*;

    localparam int LIMIT    = 1000000;
    localparam int HOLD_LEN = 300;
    localparam int SETTLE   = 6;
    localparam int PHASES   = 6;
    localparam int PHASE_ITEMS = 45;

    localparam logic [PADDR_W-1:0] ROW_ADDR = PADDR_W'(4 * int'(REG_ROW_COUNT));
    localparam logic [PADDR_W-1:0] COL_ADDR = PADDR_W'(4 * int'(REG_COL_COUNT));

    localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
    localparam logic signed [ELEM_W-1:0] ELEM_MAX = ~ELEM_MIN;

    typedef enum {
        FILL_RANDOM,
        FILL_SMALL,
        FILL_SYMMETRIC,
        FILL_IDENTITY,
        FILL_NEAR_IDENTITY,
        FILL_CONSTANT
    } t_fill_kind;

    typedef struct {
        logic signed [ELEM_W-1:0] element;
        logic                     last;
        logic [POS_W-1:0]         min_row;
        logic [POS_W-1:0]         min_col;
        logic [POS_W-1:0]         max_row;
        logic [POS_W-1:0]         max_col;
        logic                     square;
        logic                     identity;
        logic                     symmetric;
    } t_transposed;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic signed [ELEM_W-1:0] i_element;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [ELEM_W-1:0] o_out_element;
    logic                     o_is_last;
    logic [POS_W-1:0]         o_min_row;
    logic [POS_W-1:0]         o_min_col;
    logic [POS_W-1:0]         o_max_row;
    logic [POS_W-1:0]         o_max_col;
    logic                     o_square_flag;
    logic                     o_identity_flag;
    logic                     o_symmetric_flag;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [PADDR_W-1:0]       paddr;
    logic [PDATA_W-1:0]       pwdata;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;

    matrix_transpose_with_stats dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_element        (i_element),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_element    (o_out_element),
        .o_is_last        (o_is_last),
        .o_min_row        (o_min_row),
        .o_min_col        (o_min_col),
        .o_max_row        (o_max_row),
        .o_max_col        (o_max_col),
        .o_square_flag    (o_square_flag),
        .o_identity_flag  (o_identity_flag),
        .o_symmetric_flag (o_symmetric_flag),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    logic signed [ELEM_W-1:0] elem_q [$];
    t_transposed              transposed_q [$];

    int  idle_pct;
    int  stall_pct;
    bit  hold_go;
    bit  hold_seen;
    int  hold_cnt;
    int  err_cnt;
    int  cycle_cnt;

    // shadow of the block: store, load position, running stats, counts
    logic signed [ELEM_W-1:0] store_mem [DEPTH];
    int unsigned              fill_idx;
    logic signed [ELEM_W-1:0] low_val;
    logic signed [ELEM_W-1:0] high_val;
    int unsigned              low_pos;
    int unsigned              high_pos;
    bit                       ident_ok;
    logic [CNT_W-1:0]         rows_reg;
    logic [CNT_W-1:0]         cols_reg;

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    function automatic int unsigned clamp_dim(input logic [CNT_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    function automatic void restart_stats();
        fill_idx = 0;
        low_val  = '0;
        high_val = '0;
        low_pos  = 0;
        high_pos = 0;
        ident_ok = 1'b1;
    endfunction

    function automatic void load_element(input logic signed [ELEM_W-1:0] v);
        int unsigned rows, cols, total, idx, r, c, k, i, j;
        bit          square, sym, last;
        t_transposed t;
        rows  = clamp_dim(rows_reg);
        cols  = clamp_dim(cols_reg);
        total = rows * cols;
        if (fill_idx >= total) begin
            restart_stats();
        end
        idx = fill_idx;
        r   = idx / cols;
        c   = idx % cols;
        store_mem[idx] = v;
        if (idx == 0) begin
            low_val  = v;
            high_val = v;
            low_pos  = 0;
            high_pos = 0;
        end else begin
            if (v < low_val) begin
                low_val = v;
                low_pos = idx;
            end
            if (v > high_val) begin
                high_val = v;
                high_pos = idx;
            end
        end
        if (r == c) begin
            if (v != 1) ident_ok = 1'b0;
        end else if (v != 0) begin
            ident_ok = 1'b0;
        end
        if (idx + 1 < total) begin
            fill_idx = idx + 1;
            return;
        end
        square = (rows == cols);
        sym    = square;
        if (square) begin
            for (i = 0; i < rows; i++) begin
                for (j = 0; j < cols; j++) begin
                    if (store_mem[i*cols+j] != store_mem[j*cols+i]) sym = 1'b0;
                end
            end
        end
        k = 0;
        for (i = 0; i < cols; i++) begin
            for (j = 0; j < rows; j++) begin
                last        = (k + 1 == total);
                t.element   = store_mem[j*cols+i];
                t.last      = last;
                t.min_row   = last ? POS_W'(low_pos / cols) : '0;
                t.min_col   = last ? POS_W'(low_pos % cols) : '0;
                t.max_row   = last ? POS_W'(high_pos / cols) : '0;
                t.max_col   = last ? POS_W'(high_pos % cols) : '0;
                t.square    = last && square;
                t.identity  = last && square && ident_ok;
                t.symmetric = last && sym;
                transposed_q.push_back(t);
                k++;
            end
        end
        restart_stats();
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_cnt < 50) begin
            $display("mismatch %s: got %h expected %h at cycle %0d",
                     what, got, want, cycle_cnt);
        end
        err_cnt++;
    endtask

    // item driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                load_element(i_element);
            end
            if (!i_valid || !o_stall) begin
                if (elem_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    i_valid   <= 1'b1;
                    i_element <= elem_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted in cycles
    always @(posedge i_clk) begin
        if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_cnt  <= HOLD_LEN;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // result monitor and output stall
    always @(posedge i_clk) begin
        t_transposed want;
        logic        stall_n;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (transposed_q.size() == 0) begin
                    report_mismatch("unexpected result", o_out_element, '0);
                end else begin
                    want = transposed_q.pop_front();
                    if (o_out_element !== want.element)
                        report_mismatch("out_element", o_out_element, want.element);
                    if (o_is_last !== want.last)
                        report_mismatch("is_last", o_is_last, want.last);
                    if (o_min_row !== want.min_row)
                        report_mismatch("min_row", o_min_row, want.min_row);
                    if (o_min_col !== want.min_col)
                        report_mismatch("min_col", o_min_col, want.min_col);
                    if (o_max_row !== want.max_row)
                        report_mismatch("max_row", o_max_row, want.max_row);
                    if (o_max_col !== want.max_col)
                        report_mismatch("max_col", o_max_col, want.max_col);
                    if (o_square_flag !== want.square)
                        report_mismatch("square_flag", o_square_flag, want.square);
                    if (o_identity_flag !== want.identity)
                        report_mismatch("identity_flag", o_identity_flag, want.identity);
                    if (o_symmetric_flag !== want.symmetric)
                        report_mismatch("symmetric_flag", o_symmetric_flag, want.symmetric);
                end
            end
            if (hold_cnt != 0) begin
                stall_n = 1'b1;
            end else begin
                stall_n = ($urandom_range(0, 99) < stall_pct);
            end
            i_stall <= stall_n;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic signed [ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return ELEM_MIN;
            1: return ELEM_MAX;
            2: return '0;
            3: return '1;
            4: return ELEM_W'(int'($urandom_range(0, 6)) - 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_dim();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return CNT_W'($urandom_range(1, 4));
        if (r < 8) return CNT_W'($urandom_range(5, MAX_DIM));
        if (r == 8) return '0;
        return CNT_W'($urandom_range(MAX_DIM + 1, 15));
    endfunction

    function automatic t_fill_kind pick_fill();
        case ($urandom_range(0, 9))
            5: return FILL_SMALL;
            6: return FILL_SYMMETRIC;
            7: return FILL_IDENTITY;
            8: return FILL_NEAR_IDENTITY;
            9: return FILL_CONSTANT;
            default: return FILL_RANDOM;
        endcase
    endfunction

    task automatic push_matrix(input t_fill_kind kind, input int unsigned limit,
                               output int unsigned pushed);
        int unsigned              rows, cols, total, i, j, p;
        logic signed [ELEM_W-1:0] m [DEPTH];
        logic signed [ELEM_W-1:0] fixed;
        rows  = clamp_dim(rows_reg);
        cols  = clamp_dim(cols_reg);
        total = rows * cols;
        fixed = rand_elem();
        for (i = 0; i < rows; i++) begin
            for (j = 0; j < cols; j++) begin
                case (kind)
                    FILL_SMALL:
                        m[i*cols+j] = ELEM_W'(int'($urandom_range(0, 4)) - 2);
                    FILL_SYMMETRIC:
                        m[i*cols+j] = (j < i && i < cols) ? m[j*cols+i] : rand_elem();
                    FILL_IDENTITY, FILL_NEAR_IDENTITY:
                        m[i*cols+j] = (i == j) ? ELEM_W'(1) : '0;
                    FILL_CONSTANT:
                        m[i*cols+j] = fixed;
                    default:
                        m[i*cols+j] = rand_elem();
                endcase
            end
        end
        if (kind == FILL_NEAR_IDENTITY) begin
            p = $urandom_range(0, total - 1);
            m[p] = m[p] ^ (ELEM_W'(1) << $urandom_range(0, ELEM_W - 1));
        end
        pushed = (limit < total) ? limit : total;
        @(negedge i_clk);
        for (i = 0; i < pushed; i++) begin
            elem_q.push_back(m[i]);
        end
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        while (elem_q.size() != 0 || i_valid || transposed_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CNT_W-1:0] val);
        logic [PDATA_W-1:0] data;
        data = $urandom;
        data[CNT_W-1:0] = val;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= (idx == REG_ROW_COUNT) ? ROW_ADDR : COL_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ROW_COUNT) begin
            rows_reg = val;
        end else begin
            cols_reg = val;
        end
        restart_stats();
    endtask

    task automatic set_mode(input int mode);
        @(negedge i_clk);
        case (mode)
            1: begin
                idle_pct  = 74;
                stall_pct = 0;
            end
            2: begin
                idle_pct  = 0;
                stall_pct = 74;
            end
            3: begin
                idle_pct  = 11;
                stall_pct = 11;
            end
            default: begin
                idle_pct  = 0;
                stall_pct = 0;
            end
        endcase
    endtask

    initial begin
        int unsigned      sent, n;
        logic [CNT_W-1:0] dim;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_element = '0;
        i_stall   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_go   = 1'b0;
        hold_seen = 1'b0;
        hold_cnt  = 0;
        err_cnt   = 0;
        cycle_cnt = 0;
        rows_reg  = COUNT_RESET;
        cols_reg  = COUNT_RESET;
        restart_stats();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 2x2: identity, extremes, all equal
        write_reg(REG_ROW_COUNT, CNT_W'(2));
        write_reg(REG_COL_COUNT, CNT_W'(2));
        @(negedge i_clk);
        elem_q.push_back(ELEM_W'(1));
        elem_q.push_back('0);
        elem_q.push_back('0);
        elem_q.push_back(ELEM_W'(1));
        elem_q.push_back(ELEM_MIN);
        elem_q.push_back(ELEM_MAX);
        elem_q.push_back(ELEM_MAX);
        elem_q.push_back(ELEM_MIN);
        repeat (4) elem_q.push_back(ELEM_W'(7));
        wait_drain();

        // partial load dropped by a register write, counts out of range
        @(negedge i_clk);
        elem_q.push_back(ELEM_W'(3));
        wait_drain();
        write_reg(REG_ROW_COUNT, '0);
        write_reg(REG_COL_COUNT, CNT_W'(9));
        @(negedge i_clk);
        elem_q.push_back(ELEM_MIN);
        elem_q.push_back(ELEM_MAX);
        elem_q.push_back('1);
        elem_q.push_back('0);
        elem_q.push_back(32'hAAAA_AAAA);
        elem_q.push_back(32'h5555_5555);
        elem_q.push_back(ELEM_W'(1));
        elem_q.push_back(ELEM_MAX);
        wait_drain();

        // non-square
        write_reg(REG_ROW_COUNT, CNT_W'(3));
        write_reg(REG_COL_COUNT, CNT_W'(1));
        @(negedge i_clk);
        elem_q.push_back(ELEM_W'(1));
        elem_q.push_back('0);
        elem_q.push_back('0);
        wait_drain();

        // receiver holds off while full-size matrices keep coming
        set_mode(0);
        write_reg(REG_ROW_COUNT, CNT_W'(MAX_DIM));
        write_reg(REG_COL_COUNT, CNT_W'(MAX_DIM));
        @(negedge i_clk);
        hold_go = ~hold_go;
        push_matrix(FILL_RANDOM, DEPTH, n);
        push_matrix(FILL_SYMMETRIC, DEPTH, n);
        wait_drain();

        for (int p = 0; p < PHASES; p++) begin
            set_mode(p % 4);
            dim = pick_dim();
            write_reg(REG_ROW_COUNT, dim);
            write_reg(REG_COL_COUNT, ($urandom_range(0, 1) != 0) ? dim : pick_dim());
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                push_matrix(pick_fill(), DEPTH, n);
                sent += n;
                if (sent == n) begin
                    wait_drain();
                end
            end
            if (p == 4) begin
                n = clamp_dim(rows_reg) * clamp_dim(cols_reg);
                if (n > 1) begin
                    push_matrix(FILL_RANDOM, $urandom_range(1, n - 1), n);
                end
            end
            wait_drain();
        end

        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
